/* rtl/cnam_pkg.sv */
// cnam_pkg: shared types and codes of the can node absence monitor
// item structs, op and command kinds, status codes, config register indexes
// no dependencies
`default_nettype none

package cnam_pkg;

    // input item as it arrives on the input channel
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  channel;
        logic [31:0] now;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0] channel_out;
        logic [1:0] reception_status;
        logic [1:0] transmission_status;
        logic       bad_channel;
    } t_out_item;

    // op codes of the input item
    localparam logic [1:0] OP_RX_EVENT = 2'd0;
    localparam logic [1:0] OP_TX_CONF  = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // classified command kind
    typedef enum logic [1:0] {
        KIND_RX   = 2'd0,
        KIND_TX   = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NOP  = 2'd3
    } t_kind;

    // control part of a queued command, the time travels beside it
    typedef struct packed {
        t_kind      kind;
        logic       bad;
        logic [1:0] channel;
    } t_cmd;

    // status codes, shared by reception and transmission
    typedef enum logic [1:0] {
        ST_UNKNOWN   = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_CONFIRMED = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_SHORT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_LONG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE     = 2'd2;

    localparam logic [15:0] SHORT_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] LONG_TIMEOUT_RST  = 16'd5000;
    localparam logic [7:0]  TOLERANCE_RST     = 8'd0;

endpackage

`default_nettype wire

/* rtl/cnam_front.sv */
// cnam_front: input register stage, decodes op and range-checks the channel
// depends on cnam_pkg
`default_nettype none

module cnam_front
    import cnam_pkg::*;
#(
    parameter int CHANNEL_COUNT = 2,
    parameter int TIME_BITS     = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in_item             i_in_item,
    output logic                      o_in_stall,
    output logic                      o_push,
    output t_cmd                      o_cmd,
    output logic [TIME_BITS-1:0]      o_time,
    input  wire logic                 i_q_ready
);

    logic                 r_valid;
    logic                 n_valid;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    logic [TIME_BITS-1:0] r_time;
    logic                 accept;

    assign o_in_stall = r_valid && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // decode
    always_comb begin
        n_cmd.channel = i_in_item.channel;
        n_cmd.bad     = ({30'd0, i_in_item.channel} >= CHANNEL_COUNT);
        unique case (i_in_item.op)
            OP_RX_EVENT: n_cmd.kind = KIND_RX;
            OP_TX_CONF:  n_cmd.kind = KIND_TX;
            OP_TICK:     n_cmd.kind = KIND_TICK;
            OP_UNUSED:   n_cmd.kind = KIND_NOP;
            default:     n_cmd.kind = KIND_NOP;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && !i_q_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= n_cmd;
            r_time <= i_in_item.now[TIME_BITS-1:0];
        end
    end

    assign o_push = r_valid && i_q_ready;
    assign o_cmd  = r_cmd;
    assign o_time = r_time;

endmodule

`default_nettype wire

/* rtl/cnam_queue.sv */
// cnam_queue: short fifo between front and back
// no package dependencies
`default_nettype none

module cnam_queue #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* rtl/cnam_back.sv */
// cnam_back: per-channel status and judgment timers, result register
// depends on cnam_pkg
`default_nettype none

module cnam_back
    import cnam_pkg::*;
#(
    parameter int CHANNEL_COUNT = 2,
    parameter int TIME_BITS     = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_cmd                 i_cmd,
    input  wire logic [TIME_BITS-1:0] i_time,
    output logic                      o_pop,
    input  wire logic [15:0]          i_short_timeout,
    input  wire logic [15:0]          i_long_timeout,
    input  wire logic [7:0]           i_tolerance,
    output logic                      o_out_valid,
    output t_out_item                 o_out_item,
    input  wire logic                 i_out_stall
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int TW   = TIME_BITS;

    // timer slots within a channel: rx short, rx long, tx short, tx long
    localparam int TMR_RX_SHORT = 0;
    localparam int TMR_TX_SHORT = 2;

    t_status       r_rx    [CHANNEL_COUNT];
    t_status       r_tx    [CHANNEL_COUNT];
    logic [3:0]    r_run   [CHANNEL_COUNT];
    logic [3:0]    r_arr   [CHANNEL_COUNT];
    logic [TW-1:0] r_start [CHANNEL_COUNT][4];

    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    logic [CH_W-1:0] ch;
    logic [TW-1:0]   cur_start [4];
    logic [3:0]      cur_run;
    logic [3:0]      cur_arr;
    logic [3:0]      n_run;
    logic [3:0]      n_arr;
    logic [3:0]      set_start;
    t_status         n_stat [2];
    logic [1:0]      sh_hit;
    logic [1:0]      lg_hit;
    logic            write_state;

    // elapsed plus tolerance reaches the timeout
    function automatic logic due(
        input logic [TW-1:0] start,
        input logic [TW-1:0] t,
        input logic [15:0]   timeout,
        input logic [7:0]    tol
    );
        logic [TW-1:0] elapsed;
        logic [TW:0]   sum;
        elapsed = t - start;
        sum     = {1'b0, elapsed} + {{(TW - 7){1'b0}}, tol};
        return sum >= {{(TW - 15){1'b0}}, timeout};
    endfunction

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign write_state = o_pop && !i_cmd.bad;
    assign ch          = i_cmd.channel[CH_W-1:0];

    always_comb begin
        cur_run = r_run[ch];
        cur_arr = r_arr[ch];
        for (int k = 0; k < 4; k++) begin
            cur_start[k] = r_start[ch][k];
        end
    end

    // short and long check per direction, the four compares are independent
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            sh_hit[j] = cur_run[2*j] && (cur_arr[2*j] ||
                        due(cur_start[2*j], i_time, i_short_timeout, i_tolerance));
            lg_hit[j] = cur_run[2*j+1] && (cur_arr[2*j+1] ||
                        due(cur_start[2*j+1], i_time, i_long_timeout, i_tolerance));
        end
    end

    always_comb begin
        n_run     = cur_run;
        n_arr     = cur_arr;
        set_start = 4'b0000;
        n_stat[0] = r_rx[ch];
        n_stat[1] = r_tx[ch];
        unique case (i_cmd.kind)
            KIND_RX: begin
                n_run[TMR_RX_SHORT +: 2]     = 2'b11;
                n_arr[TMR_RX_SHORT +: 2]     = 2'b00;
                set_start[TMR_RX_SHORT +: 2] = 2'b11;
                n_stat[0]                    = ST_PRESENT;
            end
            KIND_TX: begin
                n_run[TMR_TX_SHORT +: 2]     = 2'b11;
                n_arr[TMR_TX_SHORT +: 2]     = 2'b00;
                set_start[TMR_TX_SHORT +: 2] = 2'b11;
                n_stat[1]                    = ST_PRESENT;
            end
            KIND_TICK: begin
                for (int j = 0; j < 2; j++) begin
                    if (sh_hit[j]) begin
                        // short timer restarts; long timer latches arrival
                        n_arr[2*j]     = 1'b0;
                        set_start[2*j] = 1'b1;
                        if (lg_hit[j]) begin
                            n_arr[2*j+1] = 1'b1;
                            n_stat[j]    = ST_CONFIRMED;
                        end else begin
                            n_stat[j]    = ST_ABSENT;
                        end
                    end
                end
            end
            KIND_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_item.channel_out = i_cmd.channel;
        n_out_item.bad_channel = i_cmd.bad;
        if (i_cmd.bad) begin
            n_out_item.reception_status    = ST_UNKNOWN;
            n_out_item.transmission_status = ST_UNKNOWN;
        end else begin
            n_out_item.reception_status    = n_stat[0];
            n_out_item.transmission_status = n_stat[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_rx[c]  <= ST_UNKNOWN;
                r_tx[c]  <= ST_UNKNOWN;
                r_run[c] <= 4'b0000;
                r_arr[c] <= 4'b0000;
            end
        end else if (write_state) begin
            r_rx[ch]  <= n_stat[0];
            r_tx[ch]  <= n_stat[1];
            r_run[ch] <= n_run;
            r_arr[ch] <= n_arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_state) begin
            for (int k = 0; k < 4; k++) begin
                if (set_start[k]) begin
                    r_start[ch][k] <= i_time;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an out-of-range channel reports no status
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.bad_channel |->
            r_out_item.reception_status == ST_UNKNOWN &&
            r_out_item.transmission_status == ST_UNKNOWN)
        else $error("bad channel item reports a status");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !o_pop)
        else $error("result register overwritten while stalled");

    // a receive event on a valid channel reports reception present
    a_rx_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_cmd.bad && i_cmd.kind == KIND_RX |=>
            r_out_item.reception_status == ST_PRESENT)
        else $error("receive event did not report present");

    // a tick whose receive short timer has arrived leaves reception absent or confirmed
    a_tick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_cmd.bad && i_cmd.kind == KIND_TICK && sh_hit[0] |=>
            (r_out_item.reception_status == ST_ABSENT ||
             r_out_item.reception_status == ST_CONFIRMED))
        else $error("arrived short timer did not judge absence");

endmodule

`default_nettype wire

/* rtl/can_node_absence_monitor.sv */
// can_node_absence_monitor: top level, config registers and front/queue/back wiring
// depends on cnam_pkg, cnam_front, cnam_queue, cnam_back
`default_nettype none

// Watches reception and transmission health of up to four CAN channels. Each
// channel keeps a reception status and a transmission status, each guarded by
// a short and a long judgment timer. A receive event (op 0) marks reception
// present and restarts both receive timers at the item's timestamp; a
// transmit confirmation (op 1) does the same for transmission. A periodic
// tick (op 2) checks both short timers of the channel: once elapsed time plus
// tolerance reaches the short timeout, that short timer restarts and the
// status goes to absent/mute, or to confirmed absent/mute when the long timer
// has also arrived. Elapsed time wraps modulo 2^TIME_BITS. Every item gives
// exactly one result carrying the statuses after the item; a channel at or
// above CHANNEL_COUNT leaves all state alone and reports bad_channel with
// zero statuses, and op 3 just reports the current statuses.
// Throughput is one item per clock while neither side stalls; an item passes
// from input acceptance to result through the input register, the two-entry
// queue and the result register, and all timer checks of one item are done in
// the same back-end update. Input and output stall independently thanks to the queue.
// Configuration (index 0 short timeout, 1 long timeout, 2 tolerance) must be
// written only while no item is in flight.
module can_node_absence_monitor
    import cnam_pkg::*;
#(
    parameter int CHANNEL_COUNT = 2,
    parameter int TIME_BITS     = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input items
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_item,
    output logic             o_in_stall,
    // result items
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  wire logic        i_out_stall
);

    localparam int Q_W = $bits(t_cmd) + TIME_BITS;

    // config registers
    logic [15:0] r_short_timeout;
    logic [15:0] r_long_timeout;
    logic [7:0]  r_tolerance;

    // front to queue
    logic                 f_push;
    t_cmd                 f_cmd;
    logic [TIME_BITS-1:0] f_time;
    logic                 q_ready;

    // queue to back
    logic                 q_valid;
    logic [Q_W-1:0]       q_data;
    logic                 b_pop;
    t_cmd                 b_cmd;
    logic [TIME_BITS-1:0] b_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_timeout <= SHORT_TIMEOUT_RST;
            r_long_timeout  <= LONG_TIMEOUT_RST;
            r_tolerance     <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHORT_TIMEOUT: r_short_timeout <= i_cfg_data;
                CFG_LONG_TIMEOUT:  r_long_timeout  <= i_cfg_data;
                CFG_TOLERANCE:     r_tolerance     <= i_cfg_data[7:0];
                default: begin
                    // unmapped index, ignored
                end
            endcase
        end
    end

    // front: accept and classify
    cnam_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .TIME_BITS     (TIME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_push     (f_push),
        .o_cmd      (f_cmd),
        .o_time     (f_time),
        .i_q_ready  (q_ready)
    );

    // queue decouples the two sides
    cnam_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_time}),
        .o_ready (q_ready),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_cmd  = t_cmd'(q_data[Q_W-1 -: $bits(t_cmd)]);
    assign b_time = q_data[TIME_BITS-1:0];

    // back: timers, statuses, result register
    cnam_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .TIME_BITS     (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (b_cmd),
        .i_time          (b_time),
        .o_pop           (b_pop),
        .i_short_timeout (r_short_timeout),
        .i_long_timeout  (r_long_timeout),
        .i_tolerance     (r_tolerance),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_item),
        .i_out_stall     (i_out_stall)
    );

endmodule

`default_nettype wire
